[rtl/core/fmbq_pkg.sv]
// shared types, codes and constants of the front middle back queue
`default_nettype none

package fmbq_pkg;

   localparam int FMBQ_CAPACITY = 1024;
   localparam int DATA_W        = 32;

   localparam logic signed [DATA_W-1:0] NEG_ONE = -32'sd1;

   typedef enum logic [2:0] {
      MODE_PUSH_FRONT  = 3'd0,
      MODE_PUSH_MIDDLE = 3'd1,
      MODE_PUSH_BACK   = 3'd2,
      MODE_POP_FRONT   = 3'd3,
      MODE_POP_MIDDLE  = 3'd4,
      MODE_POP_BACK    = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      HOP_NONE,
      HOP_PUSH_HEAD,
      HOP_PUSH_TAIL,
      HOP_POP_HEAD,
      HOP_POP_TAIL
   } half_op_type;

   typedef enum logic [1:0] {
      RSEL_ZERO,
      RSEL_NEG1,
      RSEL_FRONT,
      RSEL_BACK
   } rsel_type;

   typedef enum logic {
      WSRC_REQ,
      WSRC_XFER
   } wsrc_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_OP,
      ST_RSP,
      ST_BAL_WR
   } ctrl_state_type;

   typedef struct packed {
      logic        load;
      half_op_type front_op;
      half_op_type back_op;
      wsrc_type    wsrc;
      rsel_type    rsel;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic front_empty;
      logic back_more;
      logic need_f_to_b;
      logic need_b_to_f;
   } dp_stat_type;

endpackage

`default_nettype wire

[rtl/core/fmbq_half.sv]
// one half of the queue: a circular double-ended store in a memory
`default_nettype none

module fmbq_half
   import fmbq_pkg::*;
#(
   parameter int DEPTH = FMBQ_CAPACITY / 2 + 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire half_op_type                  op,
   input  wire logic        [DATA_W-1:0]     wdata,
   output logic             [DATA_W-1:0]     rdata,
   output logic             [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;
   logic [AW-1:0]     hd_ff, hd_in;
   logic [AW-1:0]     tl_ff, tl_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     hd_dec, tl_dec, hd_inc, tl_inc;
   logic [AW-1:0]     waddr, raddr;
   logic              wen, ren;

   assign hd_dec = (hd_ff == '0) ? AW'(DEPTH - 1) : hd_ff - 1'b1;
   assign tl_dec = (tl_ff == '0) ? AW'(DEPTH - 1) : tl_ff - 1'b1;
   assign hd_inc = (hd_ff == AW'(DEPTH - 1)) ? '0 : hd_ff + 1'b1;
   assign tl_inc = (tl_ff == AW'(DEPTH - 1)) ? '0 : tl_ff + 1'b1;

   always_comb begin
      hd_in  = hd_ff;
      tl_in  = tl_ff;
      cnt_in = cnt_ff;
      waddr  = tl_ff;
      raddr  = hd_ff;
      wen    = 1'b0;
      ren    = 1'b0;
      unique case (op)
         HOP_PUSH_HEAD: begin
            waddr  = hd_dec;
            wen    = 1'b1;
            hd_in  = hd_dec;
            cnt_in = cnt_ff + 1'b1;
         end
         HOP_PUSH_TAIL: begin
            waddr  = tl_ff;
            wen    = 1'b1;
            tl_in  = tl_inc;
            cnt_in = cnt_ff + 1'b1;
         end
         HOP_POP_HEAD: begin
            raddr  = hd_ff;
            ren    = 1'b1;
            hd_in  = hd_inc;
            cnt_in = cnt_ff - 1'b1;
         end
         HOP_POP_TAIL: begin
            raddr  = tl_dec;
            ren    = 1'b1;
            tl_in  = tl_dec;
            cnt_in = cnt_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ren) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hd_ff  <= '0;
         tl_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         hd_ff  <= hd_in;
         tl_ff  <= tl_in;
         cnt_ff <= cnt_in;
      end
   end

   assign rdata = rdata_ff;
   assign count = cnt_ff;

endmodule

`default_nettype wire

[rtl/core/fmbq_datapath.sv]
// datapath: front and back halves, request word register and result select
`default_nettype none

module fmbq_datapath
   import fmbq_pkg::*;
#(
   parameter int CAPACITY = FMBQ_CAPACITY
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dp_cmd_type               cmd,
   input  wire logic signed [DATA_W-1:0] req_value,
   output dp_stat_type                   stat,
   output logic signed [DATA_W-1:0]      rsp_popped_value
);

   localparam int DEPTH = CAPACITY / 2 + 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int NW    = $clog2(CAPACITY + 1) + 1;

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] front_rdata, back_rdata;
   logic [DATA_W-1:0] front_wdata, back_wdata;
   logic [CW-1:0]     front_cnt, back_cnt;
   logic [NW-1:0]     total;
   logic [CW:0]       front_cnt_p1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_value;
      end
   end

   assign front_wdata = (cmd.wsrc == WSRC_XFER) ? back_rdata : value_ff;
   assign back_wdata  = (cmd.wsrc == WSRC_XFER) ? front_rdata : value_ff;

   fmbq_half #(
      .DEPTH(DEPTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .op   (cmd.front_op),
      .wdata(front_wdata),
      .rdata(front_rdata),
      .count(front_cnt)
   );

   fmbq_half #(
      .DEPTH(DEPTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .op   (cmd.back_op),
      .wdata(back_wdata),
      .rdata(back_rdata),
      .count(back_cnt)
   );

   assign total        = NW'(front_cnt) + NW'(back_cnt);
   assign front_cnt_p1 = {1'b0, front_cnt} + 1'b1;

   assign stat.empty       = (total == '0);
   assign stat.full        = (total >= NW'(CAPACITY));
   assign stat.front_empty = (front_cnt == '0);
   assign stat.back_more   = (back_cnt > front_cnt);
   assign stat.need_f_to_b = (front_cnt > back_cnt);
   assign stat.need_b_to_f = ({1'b0, back_cnt} > front_cnt_p1);

   always_comb begin
      unique case (cmd.rsel)
         RSEL_ZERO:  rsp_popped_value = '0;
         RSEL_NEG1:  rsp_popped_value = NEG_ONE;
         RSEL_FRONT: rsp_popped_value = front_rdata;
         RSEL_BACK:  rsp_popped_value = back_rdata;
         default:    rsp_popped_value = '0;
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/fmbq_ctrl.sv]
// controller: sequences each word through operation, result and rebalance
`default_nettype none

module fmbq_ctrl
   import fmbq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [2:0]  req_mode,
   input  wire dp_stat_type stat,
   output logic             busy,
   output dp_cmd_type       cmd,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status
);

   ctrl_state_type state_ff, state_in;
   logic [2:0]     mode_ff, mode_in;
   status_type     status_ff, status_in;
   rsel_type       rsel_ff, rsel_in;
   logic           dir_ff, dir_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_OP;
            end
         end
         ST_OP: begin
            state_in = ST_RSP;
         end
         ST_RSP: begin
            if (stat.need_f_to_b || stat.need_b_to_f) begin
               state_in = ST_BAL_WR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_BAL_WR: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd.load     = 1'b0;
      cmd.front_op = HOP_NONE;
      cmd.back_op  = HOP_NONE;
      cmd.wsrc     = WSRC_REQ;
      cmd.rsel     = rsel_ff;
      mode_in      = mode_ff;
      status_in    = status_ff;
      rsel_in      = rsel_ff;
      dir_in       = dir_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               mode_in  = req_mode;
            end
         end
         ST_OP: begin
            status_in = STAT_OK;
            rsel_in   = RSEL_ZERO;
            unique case (mode_type'(mode_ff))
               MODE_PUSH_FRONT, MODE_PUSH_MIDDLE, MODE_PUSH_BACK: begin
                  if (stat.full) begin
                     status_in = STAT_FULL;
                  end else if (mode_type'(mode_ff) == MODE_PUSH_FRONT) begin
                     cmd.front_op = HOP_PUSH_HEAD;
                  end else if (mode_type'(mode_ff) == MODE_PUSH_MIDDLE) begin
                     cmd.back_op = HOP_PUSH_HEAD;
                  end else begin
                     cmd.back_op = HOP_PUSH_TAIL;
                  end
               end
               MODE_POP_FRONT: begin
                  if (stat.empty) begin
                     status_in = STAT_EMPTY;
                     rsel_in   = RSEL_NEG1;
                  end else if (stat.front_empty) begin
                     cmd.back_op = HOP_POP_HEAD;
                     rsel_in     = RSEL_BACK;
                  end else begin
                     cmd.front_op = HOP_POP_HEAD;
                     rsel_in      = RSEL_FRONT;
                  end
               end
               MODE_POP_MIDDLE: begin
                  if (stat.empty) begin
                     status_in = STAT_EMPTY;
                     rsel_in   = RSEL_NEG1;
                  end else if (stat.back_more) begin
                     cmd.back_op = HOP_POP_HEAD;
                     rsel_in     = RSEL_BACK;
                  end else begin
                     cmd.front_op = HOP_POP_TAIL;
                     rsel_in      = RSEL_FRONT;
                  end
               end
               MODE_POP_BACK: begin
                  if (stat.empty) begin
                     status_in = STAT_EMPTY;
                     rsel_in   = RSEL_NEG1;
                  end else begin
                     cmd.back_op = HOP_POP_TAIL;
                     rsel_in     = RSEL_BACK;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_RSP: begin
            // move one word across the split to keep the halves even
            if (stat.need_f_to_b) begin
               cmd.front_op = HOP_POP_TAIL;
               dir_in       = 1'b1;
            end else if (stat.need_b_to_f) begin
               cmd.back_op = HOP_POP_HEAD;
               dir_in      = 1'b0;
            end
         end
         ST_BAL_WR: begin
            cmd.wsrc = WSRC_XFER;
            if (dir_ff) begin
               cmd.back_op = HOP_PUSH_HEAD;
            end else begin
               cmd.front_op = HOP_PUSH_TAIL;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mode_ff   <= '0;
         status_ff <= STAT_OK;
         rsel_ff   <= RSEL_ZERO;
         dir_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         status_ff <= status_in;
         rsel_ff   <= rsel_in;
         dir_ff    <= dir_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RSP);
   assign rsp_status = status_ff;

endmodule

`default_nettype wire

[rtl/core/front_middle_back_queue_top.sv]
// top level of the front middle back queue
`default_nettype none

// A bounded queue of signed 32-bit words, open at front, middle and back. A word is taken
// when start is high and busy is low; each word gives exactly one result, shown on the rsp_
// ports for a single cycle with rsp_valid high, and it must be taken in that cycle because
// the block cannot be held off. The result reaches the rsp_ ports after the word has passed
// through the ST_OP state into ST_RSP. The next word is taken only after the block has
// passed through ST_OP and ST_RSP, and through ST_BAL_WR as well when the two halves of
// the store must be rebalanced afterwards, which costs one memory read and one memory
// write. The store is two circular memories of CAPACITY/2+1 words, one holding the front
// half and one the back half, each with one write or one registered read per cycle.
// No clearing pass runs after reset.
module front_middle_back_queue_top
   import fmbq_pkg::*;
#(
   parameter int CAPACITY = FMBQ_CAPACITY
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [2:0]               req_mode,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   output logic signed [DATA_W-1:0]      rsp_popped_value,
   output logic [1:0]                    rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   fmbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .stat      (stat),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_status(rsp_status)
   );

   fmbq_datapath #(
      .CAPACITY(CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_value       (req_value),
      .stat            (stat),
      .rsp_popped_value(rsp_popped_value)
   );

endmodule

`default_nettype wire
